### rtl/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the checker module; depends on signals clk and arst_n in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");

`endif

### rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

	localparam int Q_W    = 32;
	localparam int DIFF_W = 34;
	localparam int MAG_W  = 33;

	localparam logic [MAG_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
	localparam logic [MAG_W-1:0] LIM_NEG = 33'h0_8000_0000;
	localparam logic [Q_W-1:0]   SAT_HI  = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef struct packed {
		branch_t    big;
		logic       invalid;
		logic [2:0] neg;
	} ctl_t;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
// The square root and the dividers are fully pipelined.
// Throughput: one matrix per cycle while the output register is not stalled.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mat_valid,
	output logic                  mat_ready,
	input  logic signed [Q_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                  quat_valid,
	input  logic                  quat_ready,
	output logic signed [Q_W-1:0] qw, qx, qy, qz,
	output logic                  invalid
);

	localparam int RW     = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 3;
	localparam int XW     = RW - 1 + FRAC_BITS;
	localparam int TW     = (XW + 1) / 2;
	localparam int SW     = TW + 1;
	localparam int CW     = $bits(ctl_t);
	localparam int SIDE1  = CW + 3 * MAG_W;
	localparam int SIDE2  = CW + TW - 1;

	logic                  en;
	logic                  v_s1, v_sq, v_dv;
	logic [XW-1:0]         rad_s1;
	logic [2:0][MAG_W-1:0] mag_s1, mag_sq, quo;
	ctl_t                  ctl_s1, ctl_sq, ctl_dv;
	logic [TW-1:0]         root;
	logic [TW-2:0]         quarter;
	logic [2:0]            ovf;
	logic [Q_W-1:0]        lane [3];
	logic [Q_W-1:0]        qtr;
	logic [MAG_W-1:0]      lim, sat;
	logic                  out_v_q;
	logic [Q_W-1:0]        qw_q, qx_q, qy_q, qz_q;
	logic                  inv_q;

	assign en        = ~out_v_q | quat_ready;
	assign mat_ready = en;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .en, .in_v(mat_valid),
		.m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
		.v_s1, .rad_s1, .mag_s1, .ctl_s1
	);

	rmq_sqrt #(.XW(XW), .SIDE_W(SIDE1)) u_sqrt (
		.clk, .arst_n, .en, .in_v(v_s1), .rad(rad_s1),
		.side_in({ctl_s1, mag_s1}),
		.out_v(v_sq), .root,
		.side_out({ctl_sq, mag_sq})
	);

	rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .SIDE_W(SIDE2)) u_div (
		.clk, .arst_n, .en, .in_v(v_sq),
		.den({root, 1'b0}), .mag(mag_sq),
		.side_in({ctl_sq, root[TW-1:1]}),
		.out_v(v_dv), .quo, .ovf,
		.side_out({ctl_dv, quarter})
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lim     = ctl_dv.neg[k] ? LIM_NEG : LIM_POS;
			sat     = (ovf[k] || quo[k] > lim) ? lim : quo[k];
			lane[k] = ctl_dv.neg[k] ? -sat[Q_W-1:0] : sat[Q_W-1:0];
		end
		qtr = (quarter > (TW-1)'(SAT_HI)) ? SAT_HI : Q_W'(quarter);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q <= ctl_dv.invalid;
			if (ctl_dv.invalid) begin
				qw_q <= '0; qx_q <= '0; qy_q <= '0; qz_q <= '0;
			end else begin
				case (ctl_dv.big)
					BR_TRACE: begin
						qw_q <= qtr;     qx_q <= lane[0]; qy_q <= lane[1]; qz_q <= lane[2];
					end
					BR_X: begin
						qw_q <= lane[0]; qx_q <= qtr;     qy_q <= lane[1]; qz_q <= lane[2];
					end
					BR_Y: begin
						qw_q <= lane[0]; qx_q <= lane[1]; qy_q <= qtr;     qz_q <= lane[2];
					end
					default: begin
						qw_q <= lane[0]; qx_q <= lane[1]; qy_q <= lane[2]; qz_q <= qtr;
					end
				endcase
			end
		end
	end

	assign quat_valid = out_v_q;
	assign qw         = qw_q;
	assign qx         = qx_q;
	assign qy         = qy_q;
	assign qz         = qz_q;
	assign invalid    = inv_q;

endmodule

### rtl/rmq_front.sv
// Input stage: branch selection, radicand and the three signed sums.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = 30,
	localparam int RW = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 3,
	localparam int XW = RW - 1 + FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic signed [Q_W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                    v_s1,
	output logic [XW-1:0]           rad_s1,
	output logic [2:0][MAG_W-1:0]   mag_s1,
	output ctl_t                    ctl_s1
);

	localparam logic signed [RW-1:0] ONE = RW'(1) << FRAC_BITS;

	logic signed [DIFF_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [DIFF_W-1:0] tr, sel;
	logic signed [DIFF_W-1:0] d [3];
	logic signed [RW-1:0]     r;
	branch_t                  big;
	logic                     bad;

	always_comb begin
		e00 = DIFF_W'(m00); e01 = DIFF_W'(m01); e02 = DIFF_W'(m02);
		e10 = DIFF_W'(m10); e11 = DIFF_W'(m11); e12 = DIFF_W'(m12);
		e20 = DIFF_W'(m20); e21 = DIFF_W'(m21); e22 = DIFF_W'(m22);
		tr = e00 + e11 + e22;
		if (tr > 0) begin
			big = BR_TRACE; sel = tr;
			d[0] = e21 - e12; d[1] = e02 - e20; d[2] = e10 - e01;
		end else if (e00 > e11 && e00 > e22) begin
			big = BR_X; sel = e00 - e11 - e22;
			d[0] = e21 - e12; d[1] = e01 + e10; d[2] = e02 + e20;
		end else if (e11 > e22) begin
			big = BR_Y; sel = e11 - e00 - e22;
			d[0] = e02 - e20; d[1] = e01 + e10; d[2] = e12 + e21;
		end else begin
			big = BR_Z; sel = e22 - e00 - e11;
			d[0] = e10 - e01; d[1] = e02 + e20; d[2] = e12 + e21;
		end
		r = ONE + RW'(sel);
		bad = (r <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= bad ? '0 : {r[RW-2:0], {FRAC_BITS{1'b0}}};
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= d[k][DIFF_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
			end
			ctl_s1.big     <= big;
			ctl_s1.invalid <= bad;
			ctl_s1.neg     <= {d[2][DIFF_W-1], d[1][DIFF_W-1], d[0][DIFF_W-1]};
		end
	end

endmodule

### rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg only through the common import.
module rmq_sqrt import rmq_pkg::*; #(
	parameter int XW = 65,
	parameter int SIDE_W = 8,
	localparam int TW = (XW + 1) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [XW-1:0]     rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [TW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int PW  = 2 * TW;
	localparam int RMW = TW + 2;

	logic              v_p    [TW+1];
	logic [PW-1:0]     x_p    [TW+1];
	logic [RMW-1:0]    rem_p  [TW+1];
	logic [TW-1:0]     root_p [TW+1];
	logic [SIDE_W-1:0] side_p [TW+1];

	assign v_p[0]    = in_v;
	assign x_p[0]    = PW'(rad);
	assign rem_p[0]  = '0;
	assign root_p[0] = '0;
	assign side_p[0] = side_in;

	for (genvar i = 0; i < TW; i++) begin : g_stg
		logic [RMW+1:0]    rem_sh, trial;
		logic              ge;
		logic              v_s;
		logic [PW-1:0]     x_s;
		logic [RMW-1:0]    rem_s;
		logic [TW-1:0]     root_s;
		logic [SIDE_W-1:0] side_s;

		always_comb begin
			rem_sh = {rem_p[i], x_p[i][PW-1 -: 2]};
			trial  = (RMW+2)'({root_p[i], 2'b01});
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en) begin
				v_s <= v_p[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s    <= x_p[i] << 2;
				rem_s  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
				root_s <= {root_p[i][TW-2:0], ge};
				side_s <= side_p[i];
			end
		end

		assign v_p[i+1]    = v_s;
		assign x_p[i+1]    = x_s;
		assign rem_p[i+1]  = rem_s;
		assign root_p[i+1] = root_s;
		assign side_p[i+1] = side_s;
	end

	assign out_v    = v_p[TW];
	assign root     = root_p[TW];
	assign side_out = side_p[TW];

endmodule

### rtl/rmq_div.sv
// Pipelined three-lane fixed-point divider: an overflow check stage, then
// one quotient bit per stage. Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; #(
	parameter int FRAC_BITS = 30,
	parameter int SW = 34,
	parameter int SIDE_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic [SW-1:0]         den,
	input  logic [2:0][MAG_W-1:0] mag,
	input  logic [SIDE_W-1:0]     side_in,
	output logic                  out_v,
	output logic [2:0][MAG_W-1:0] quo,
	output logic [2:0]            ovf,
	output logic [SIDE_W-1:0]     side_out
);

	localparam int NW = MAG_W + FRAC_BITS;

	logic                  v_p    [MAG_W+1];
	logic [SW-1:0]         den_p  [MAG_W+1];
	logic [2:0][SW-1:0]    rem_p  [MAG_W+1];
	logic [2:0][MAG_W-1:0] low_p  [MAG_W+1];
	logic [2:0][MAG_W-1:0] q_p    [MAG_W+1];
	logic [2:0]            ovf_p  [MAG_W+1];
	logic [SIDE_W-1:0]     side_p [MAG_W+1];

	logic                  v_s0;
	logic [SW-1:0]         den_s0;
	logic [2:0][SW-1:0]    rem_s0;
	logic [2:0][MAG_W-1:0] low_s0;
	logic [2:0]            ovf_s0;
	logic [SIDE_W-1:0]     side_s0;
	logic [NW-1:0]         num [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = {mag[k], {FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s0  <= den;
			side_s0 <= side_in;
			for (int k = 0; k < 3; k++) begin
				rem_s0[k] <= SW'(num[k][NW-1:MAG_W]);
				low_s0[k] <= num[k][MAG_W-1:0];
				ovf_s0[k] <= (SW'(num[k][NW-1:MAG_W]) >= den);
			end
		end
	end

	assign v_p[0]    = v_s0;
	assign den_p[0]  = den_s0;
	assign rem_p[0]  = rem_s0;
	assign low_p[0]  = low_s0;
	assign q_p[0]    = '0;
	assign ovf_p[0]  = ovf_s0;
	assign side_p[0] = side_s0;

	for (genvar i = 0; i < MAG_W; i++) begin : g_stg
		logic [SW:0]           rem_sh [3];
		logic [2:0]            ge;
		logic                  v_s;
		logic [SW-1:0]         den_s;
		logic [2:0][SW-1:0]    rem_s;
		logic [2:0][MAG_W-1:0] low_s;
		logic [2:0][MAG_W-1:0] q_s;
		logic [2:0]            ovf_s;
		logic [SIDE_W-1:0]     side_s;

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				rem_sh[k] = {rem_p[i][k], low_p[i][k][MAG_W-1]};
				ge[k]     = (rem_sh[k] >= {1'b0, den_p[i]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en) begin
				v_s <= v_p[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s  <= den_p[i];
				ovf_s  <= ovf_p[i];
				side_s <= side_p[i];
				for (int k = 0; k < 3; k++) begin
					rem_s[k] <= ge[k] ? SW'(rem_sh[k] - {1'b0, den_p[i]}) : SW'(rem_sh[k]);
					low_s[k] <= low_p[i][k] << 1;
					q_s[k]   <= {q_p[i][k][MAG_W-2:0], ge[k]};
				end
			end
		end

		assign v_p[i+1]    = v_s;
		assign den_p[i+1]  = den_s;
		assign rem_p[i+1]  = rem_s;
		assign low_p[i+1]  = low_s;
		assign q_p[i+1]    = q_s;
		assign ovf_p[i+1]  = ovf_s;
		assign side_p[i+1] = side_s;
	end

	assign out_v    = v_p[MAG_W];
	assign quo      = q_p[MAG_W];
	assign ovf      = ovf_p[MAG_W];
	assign side_out = side_p[MAG_W];

endmodule

### rtl/rmq_checker.sv
// Port-level checker for rotation_matrix_to_quaternion, attached by bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh.
`include "rotation_matrix_to_quaternion_macros.svh"
module rmq_checker import rmq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  mat_ready,
	input logic                  quat_valid,
	input logic                  quat_ready,
	input logic signed [Q_W-1:0] qw, qx, qy, qz,
	input logic                  invalid
);

	`RMQ_ASSERT_NOW(a_invalid_zero, quat_valid && invalid, qw == 0 && qx == 0 && qy == 0 && qz == 0)
	`RMQ_ASSERT_NOW(a_stall_blocks_input, quat_valid && !quat_ready, !mat_ready)
	`RMQ_ASSERT_NOW(a_empty_accepts, !quat_valid, mat_ready)
	`RMQ_ASSERT_NEXT(a_out_hold, quat_valid && !quat_ready, quat_valid && $stable(qw) && $stable(invalid))

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
